/* hw/rtl/itbd_pkg.sv */
// Shared constants for the integer to base digits converter.
`default_nettype none
package itbd_pkg;

  localparam int DIGIT_BITS     = 4;
  localparam int COUNT_BITS     = 6;
  localparam int RADIX_BITS     = 4;
  localparam int STORE_DEPTH    = 64;
  localparam int ADDR_BITS      = 6;
  localparam int BITS_PER_STEP  = 8;
  localparam int IN_TDATA_BITS  = 64;
  localparam int OUT_TDATA_BITS = 16;
  localparam int CFG_ADDR_BITS  = 1;
  localparam int CFG_DATA_BITS  = 4;

  localparam logic [CFG_ADDR_BITS-1:0] REG_RADIX     = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MSD_FIRST = 1'd1;

  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 4'd10;
  localparam logic [RADIX_BITS-1:0] MIN_BASE    = 4'd2;
  localparam logic [RADIX_BITS-1:0] MAX_BASE    = 4'd10;

endpackage
`default_nettype wire

/* hw/rtl/itbd_div.sv */
// Iterative divider of a wide value by a small base, several quotient bits per cycle.
`default_nettype none
module itbd_div #(
  parameter int W = 63
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [W-1:0]                    dividend,
  input  wire logic [itbd_pkg::RADIX_BITS-1:0] base,
  output logic                                 done,
  output logic [W-1:0]                         quotient,
  output logic [itbd_pkg::DIGIT_BITS-1:0]      rem
);
  import itbd_pkg::*;

  localparam int STEPS    = (W + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int NW       = STEPS * BITS_PER_STEP;
  localparam int CNT_BITS = $clog2(STEPS + 1);

  logic [NW-1:0]         num, num_next;
  logic [DIGIT_BITS-1:0] rem_q, rem_next;
  logic [CNT_BITS-1:0]   cnt;
  logic                  active;
  logic [DIGIT_BITS:0]   t;

  // long division, MSB first: BITS_PER_STEP shift/compare/subtract steps per cycle
  always_comb begin
    num_next = num;
    rem_next = rem_q;
    t        = '0;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      t        = {rem_next, num_next[NW-1]};
      num_next = {num_next[NW-2:0], 1'b0};
      if (t >= {1'b0, base}) begin
        t           = t - {1'b0, base};
        num_next[0] = 1'b1;
      end
      rem_next = t[DIGIT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_BITS'(STEPS);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num   <= NW'(dividend);
      rem_q <= '0;
    end else if (active) begin
      num   <= num_next;
      rem_q <= rem_next;
    end
  end

  assign quotient = num[W-1:0];
  assign rem      = rem_q;

endmodule
`default_nettype wire

/* hw/rtl/itbd_store.sv */
// Digit memory: one write port, one registered read port.
`default_nettype none
module itbd_store (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [itbd_pkg::ADDR_BITS-1:0]  waddr,
  input  wire logic [itbd_pkg::DIGIT_BITS-1:0] wdata,
  input  wire logic                            re,
  input  wire logic [itbd_pkg::ADDR_BITS-1:0]  raddr,
  output logic [itbd_pkg::DIGIT_BITS-1:0]      rdata
);
  import itbd_pkg::*;

  logic [DIGIT_BITS-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/integer_to_base_digits_top.sv */
// Top level: converts a non-negative integer into its digits in base 2 to 10.
//
// Usage:
//   s_* channel: one beat per value, s_tdata[62:0] holds the integer (only the
//   low VALUE_BITS bits count). s_tready is high only while the block is idle.
//   m_* channel: one beat per digit; tdata = digit, place, digit_count; tlast
//   marks the final digit of a value. A zero value gives one beat: digit 0,
//   place 0, digit_count 0, tlast 1.
//   cfg_*: write radix (index 0, out-of-range values clamp to 2..10) and
//   msd_first (index 1: 0 = least significant first, 1 = most significant first).
// Timing:
//   A shared divider retires 8 quotient bits per cycle to yield each digit; the
//   digits then leave one by one through the digit memory's registered read
//   port, each read in S_READ and loaded in S_LOAD. No new value is taken
//   until the last digit of a value is loaded into the output register.
// Reset: synchronous, clears the sequencer, output valid and registers to
//   radix 10, least significant first.
// Stall: the output register holds its beat while m_tready is low and the
//   sequencer waits; the next value is taken while the last beat still waits.
`default_nettype none
module integer_to_base_digits_top #(
  parameter int VALUE_BITS = 63
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [itbd_pkg::IN_TDATA_BITS-1:0]  s_tdata,  // [62:0] value
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [itbd_pkg::OUT_TDATA_BITS-1:0]      m_tdata,  // [3:0] digit, [9:4] place,
                                                             // [15:10] digit_count
  output logic                                     m_tlast,
  input  wire logic                                cfg_we,
  input  wire logic [itbd_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  wire logic [itbd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import itbd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_READ = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t state;

  // configuration
  logic [RADIX_BITS-1:0] radix;
  logic                  msd_first;
  logic [RADIX_BITS-1:0] base;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= RADIX_RESET;
      msd_first <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RADIX:     radix     <= cfg_wdata[RADIX_BITS-1:0];
        REG_MSD_FIRST: msd_first <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign base = (radix < MIN_BASE) ? MIN_BASE :
                (radix > MAX_BASE) ? MAX_BASE : radix;

  // input side
  logic [VALUE_BITS-1:0] in_value;
  logic                  in_accept;
  logic                  in_nonzero;

  assign s_tready   = (state == S_IDLE) && !rst;
  assign in_accept  = s_tvalid && s_tready;
  assign in_value   = s_tdata[VALUE_BITS-1:0];
  assign in_nonzero = |in_value;

  // shared divider
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] quotient;
  logic [DIGIT_BITS-1:0] rem;
  logic                  quo_zero;

  assign quo_zero  = (quotient == '0);
  assign div_start = (in_accept && in_nonzero) ||
                     ((state == S_DIV) && div_done && !quo_zero);

  itbd_div #(
    .W (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_accept ? in_value : quotient),
    .base     (base),
    .done     (div_done),
    .quotient (quotient),
    .rem      (rem)
  );

  // digit memory
  logic [COUNT_BITS-1:0] count;     // digits found so far / digit count
  logic [COUNT_BITS-1:0] idx;       // emit index
  logic [ADDR_BITS-1:0]  plc_calc;
  logic [ADDR_BITS-1:0]  plc_r;
  logic                  last_r;
  logic                  zero_val;
  logic [DIGIT_BITS-1:0] rd_digit;
  logic                  st_we;
  logic                  st_re;
  logic                  out_free;

  assign st_we    = (state == S_DIV) && div_done;
  assign st_re    = (state == S_READ);
  assign plc_calc = msd_first ? ADDR_BITS'(count - 6'd1 - idx) : ADDR_BITS'(idx);
  assign out_free = !m_tvalid || m_tready;

  itbd_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (ADDR_BITS'(count)),
    .wdata (rem),
    .re    (st_re),
    .raddr (plc_calc),
    .rdata (rd_digit)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      idx      <= '0;
      zero_val <= 1'b0;
      plc_r    <= '0;
      last_r   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            count <= '0;
            idx   <= '0;
            if (in_nonzero) begin
              zero_val <= 1'b0;
              state    <= S_DIV;
            end else begin
              // zero: single beat, no division
              zero_val <= 1'b1;
              plc_r    <= '0;
              last_r   <= 1'b1;
              state    <= S_LOAD;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            count <= count + 1'b1;
            if (quo_zero) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          plc_r  <= plc_calc;
          last_r <= (idx == count - 6'd1);
          state  <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            if (last_r) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  logic                  load;
  logic [DIGIT_BITS-1:0] o_digit;
  logic [COUNT_BITS-1:0] o_place;
  logic [COUNT_BITS-1:0] o_count;

  assign load = (state == S_LOAD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_digit <= zero_val ? '0 : rd_digit;
      o_place <= COUNT_BITS'(plc_r);
      o_count <= count;
      m_tlast <= last_r;
    end
  end

  assign m_tdata = {o_count, o_place, o_digit};

endmodule
`default_nettype wire

/* tb/integer_to_base_digits_top_test.sv */
// Testbench for integer_to_base_digits_top: random and directed values checked digit by digit.
`timescale 1ns / 1ps
module integer_to_base_digits_top_test;
  import itbd_pkg::*;

  // Cycles with no beat on either side and no register write before the run is declared
  // hung. The slowest value (63 digits, base 2, most significant first) must be fully
  // divided before its first digit leaves, and the long receiver hold-off adds to that.
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_HOLD      = 400;  // receiver hold-off that backs the block up
  localparam int HOLD_AFTER     = 40;   // values taken before that hold-off starts
  localparam int SETTLE_CYCLES  = 16;   // quiet cycles after draining, before the next plan step
  localparam int TAIL_CYCLES    = 50;   // quiet cycles at the end to catch stray beats

  // What the stimulus plan holds: a value to send, a register write, or a pause
  // that waits for every pending digit to come out.
  typedef enum logic [1:0] {
    STEP_VALUE,
    STEP_REG,
    STEP_SETTLE
  } step_kind_t;

  typedef struct {
    step_kind_t                kind;
    logic [62:0]               value;
    logic [CFG_ADDR_BITS-1:0]  addr;
    logic [CFG_DATA_BITS-1:0]  data;
  } plan_step_t;

  // One expected output beat.
  typedef struct {
    logic [DIGIT_BITS-1:0]  digit;
    logic [COUNT_BITS-1:0]  place;
    logic [COUNT_BITS-1:0]  count;
    logic                   last;
  } digit_beat_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [IN_TDATA_BITS-1:0]    s_tdata = '0;   // [62:0] value, [63] zero fill
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0]   m_tdata;        // [3:0] digit, [9:4] place, [15:10] digit_count
  logic                        m_tlast;
  logic                        cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0]    cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0]    cfg_wdata = '0;

  plan_step_t   plan[$];         // pending stimulus, filled up front
  digit_beat_t  digits_due[$];   // predicted digits not yet seen on the output

  // Our copy of the block's registers, as they stand after reset.
  logic [RADIX_BITS-1:0]  radix_copy = RADIX_RESET;
  logic                   msd_copy   = 1'b0;

  int   values_taken = 0;        // input beats accepted (updated with NBA, read elsewhere)
  int   fault_count  = 0;
  int   gap_left     = 0;
  int   settle_left  = 0;
  bit   send_eager   = 1'b1;
  int   stall_left   = 0;
  bit   take_eager   = 1'b1;
  bit   long_hold_done = 1'b0;
  int   idle_cycles  = 0;

  integer_to_base_digits_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Digit predictor: splits a value by repeated division in the effective base
  // (radix clamped to 2..10) and queues the beats in the configured order.
  // Zero is a special case: a single digit 0 with a digit count of 0.
  // ---------------------------------------------------------------------------
  function automatic void predict_digits(input logic [62:0] value);
    logic [62:0]            quotient;
    logic [RADIX_BITS-1:0]  base;
    logic [DIGIT_BITS-1:0]  by_place[64];
    int                     n;
    int                     plc;
    digit_beat_t            beat;
    base = radix_copy;
    if (base < MIN_BASE) base = MIN_BASE;
    if (base > MAX_BASE) base = MAX_BASE;
    quotient = value;
    if (quotient == '0) begin
      beat = '{digit: '0, place: '0, count: '0, last: 1'b1};
      digits_due.insert(digits_due.size(), beat);
      return;
    end
    n = 0;
    while (quotient != '0) begin
      by_place[n] = DIGIT_BITS'(quotient % base);
      quotient    = quotient / base;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      plc = msd_copy ? (n - 1 - i) : i;
      beat.digit = by_place[plc];
      beat.place = COUNT_BITS'(plc);
      beat.count = COUNT_BITS'(n);
      beat.last  = (i == n - 1);
      digits_due.insert(digits_due.size(), beat);
    end
  endfunction

  // Gap lengths: mostly short, now and then long.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 12) return $urandom_range(0, 3);
    if (r < 15) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Values mostly of moderate width, with zero, all ones and full-width random mixed in.
  function automatic logic [62:0] rand_value();
    logic [63:0] raw;
    int          width;
    int          pick;
    pick = $urandom_range(0, 15);
    raw  = {$urandom, $urandom};
    if (pick == 0) return '0;
    if (pick == 1) return {63{1'b1}};
    if (pick <= 3) return raw[62:0];
    if (pick <= 5) return 63'($urandom_range(0, 120));
    width = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 62) : $urandom_range(1, 32);
    return raw[62:0] & ((63'd1 << width) - 63'd1);
  endfunction

  task automatic add_value(input logic [62:0] v);
    plan_step_t s;
    s = '{kind: STEP_VALUE, value: v, addr: '0, data: '0};
    plan.insert(plan.size(), s);
  endtask

  // Wait for the block to drain before going on.
  task automatic add_pause();
    plan_step_t s;
    s = '{kind: STEP_SETTLE, value: '0, addr: '0, data: '0};
    plan.insert(plan.size(), s);
  endtask

  // Register writes only ever follow a full drain.
  task automatic add_reg(input logic [CFG_ADDR_BITS-1:0] a, input logic [CFG_DATA_BITS-1:0] d);
    plan_step_t s;
    add_pause();
    s = '{kind: STEP_REG, value: '0, addr: a, data: d};
    plan.insert(plan.size(), s);
  endtask

  task automatic build_plan();
    logic [CFG_DATA_BITS-1:0] rdx;
    logic [CFG_DATA_BITS-1:0] ord;
    // Directed: reset config (base 10, least significant first).
    add_value('0);
    add_value(63'd1);
    add_value(63'd9);
    add_value(63'd10);
    add_value({63{1'b1}});
    add_value(63'd12345);
    // Base 2, most significant first: longest digit string, zero in that order too.
    add_reg(REG_RADIX, 4'd2);
    add_reg(REG_MSD_FIRST, 4'd1);
    add_value('0);
    add_value(63'd1);
    add_value({63{1'b1}});
    add_value(63'd5);
    add_value(63'h4000_0000_0000_0000);
    // Radix below two clamps to 2, above ten clamps to 10.
    add_reg(REG_RADIX, 4'd0);
    add_value(63'd6);
    add_reg(REG_RADIX, 4'd1);
    add_value(63'd3);
    add_reg(REG_RADIX, 4'd15);
    add_value(63'd99);
    add_reg(REG_RADIX, 4'd11);
    add_value(63'd100);
    // Only bit 0 of the order register counts.
    add_reg(REG_RADIX, 4'd3);
    add_reg(REG_MSD_FIRST, 4'hE);
    add_value({63{1'b1}});
    add_value(63'd8);
    add_reg(REG_RADIX, 4'd9);
    add_reg(REG_MSD_FIRST, 4'd1);
    add_value(63'd80);
    add_value(63'd81);
    add_reg(REG_RADIX, 4'd7);
    add_value('0);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       rdx = 4'd2;
        1:       rdx = 4'd10;
        2:       rdx = 4'd0;
        3:       rdx = 4'd15;
        default: rdx = CFG_DATA_BITS'($urandom_range(0, 15));
      endcase
      case (ph)
        0:       ord = 4'd1;
        1:       ord = 4'd0;
        default: ord = CFG_DATA_BITS'($urandom_range(0, 15));
      endcase
      add_reg(REG_RADIX, rdx);
      add_reg(REG_MSD_FIRST, ord);
      for (int k = 0; k < 15; k++) begin
        // Sender stops mid-phase until everything is out.
        if (ph == 2 && k == 9) add_pause();
        add_value(rand_value());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: walks the plan. A value beat is predicted at the edge where
  // it is accepted, using the register copy in force then.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic offer;
    logic we;
    if (rst) begin
      s_tvalid    <= 1'b0;
      cfg_we      <= 1'b0;
      gap_left    = 0;
      settle_left = 0;
    end else begin
      offer = s_tvalid;
      we    = 1'b0;
      if (s_tvalid && s_tready) begin
        predict_digits(s_tdata[62:0]);
        values_taken <= values_taken + 1;
        offer = 1'b0;
        if ($urandom_range(0, 15) == 0) send_eager = !send_eager;
        gap_left = send_eager ? 0 : rand_gap();
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (settle_left > 0) begin
          settle_left--;
        end else if (plan.size() != 0) begin
          case (plan[0].kind)
            STEP_VALUE: begin
              s_tdata <= {1'b0, plan[0].value};
              offer = 1'b1;
              void'(plan.pop_front());
            end
            STEP_REG: begin
              we = 1'b1;
              cfg_addr  <= plan[0].addr;
              cfg_wdata <= plan[0].data;
              case (plan[0].addr)
                REG_RADIX:     radix_copy = plan[0].data;
                REG_MSD_FIRST: msd_copy   = plan[0].data[0];
                default: ;
              endcase
              void'(plan.pop_front());
            end
            STEP_SETTLE: begin
              // Hold until every predicted digit has come out, then a quiet spell.
              if (digits_due.size() == 0) begin
                settle_left = SETTLE_CYCLES;
                void'(plan.pop_front());
              end
            end
            default: ;
          endcase
        end
      end
      s_tvalid <= offer;
      cfg_we   <= we;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: runs of full readiness alternate with random stalls. Once, after
  // HOLD_AFTER values, it holds off in one long stall so the block backs up
  // and drops s_tready while the driver keeps offering.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : take
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left = 0;
    end else begin
      if (!long_hold_done && values_taken >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) take_eager = !take_eager;
        if (take_eager || $urandom_range(0, 3) != 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready   <= 1'b0;
          stall_left = rand_gap();
        end
      end
    end
  end

  task automatic log_fault(input string msg);
    if (fault_count < 10) $display("%s", msg);
    fault_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Output monitor: each accepted beat against the oldest predicted digit.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check
    digit_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (digits_due.size() == 0) begin
        log_fault($sformatf("unexpected beat: digit %0d place %0d count %0d last %0b",
                            m_tdata[3:0], m_tdata[9:4], m_tdata[15:10], m_tlast));
      end else begin
        want = digits_due.pop_front();
        if (m_tdata[3:0] !== want.digit || m_tdata[9:4] !== want.place ||
            m_tdata[15:10] !== want.count || m_tlast !== want.last) begin
          log_fault($sformatf(
            "mismatch: want digit %0d place %0d count %0d last %0b, got %0d %0d %0d %0b",
            want.digit, want.place, want.count, want.last,
            m_tdata[3:0], m_tdata[9:4], m_tdata[15:10], m_tlast));
        end
      end
    end
  end

  // Watchdog: too long without any beat or register write means the block hung.
  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Plan, reset, then wait for the plan and the predicted digits to run dry.
  initial begin
    build_plan();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (plan.size() != 0 || s_tvalid || digits_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (digits_due.size() != 0) log_fault("digits still expected at end of run");
    if (fault_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
